### rtl/sha1sh_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Shared types and constants for the byte-serial SHA-1 hasher.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

  localparam int Rounds      = 80;
  localparam int DigestWords = 5;

  typedef logic [31:0] word_t;
  typedef logic [DigestWords-1:0][31:0] chain_t;

  // Initial chaining values, element 0 is H0.
  localparam chain_t H_INIT = {32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE,
                               32'hEFCDAB89, 32'h67452301};

  localparam logic [7:0] PAD_MARK = 8'h80;
  localparam logic [5:0] LEN_POS  = 6'd56;  // first byte of the bit length
  localparam logic [5:0] LAST_POS = 6'd63;  // last byte of a block

  // Round group, selects the boolean function and the round constant.
  typedef enum logic [1:0] {
    PH_CHOOSE,
    PH_PARITY_LO,
    PH_MAJORITY,
    PH_PARITY_HI
  } phase_t;

  typedef struct packed {
    logic       wr_en;
    logic [5:0] wr_pos;
    logic [7:0] wr_byte;
    logic       shift;
  } sched_ctl_t;

  typedef struct packed {
    logic   load;
    logic   step;
    phase_t phase;
  } round_ctl_t;

endpackage
`default_nettype wire

### rtl/sha1sh_sched.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1sh_sched
// Block buffer and message schedule: 16-word shift line with expansion taps.
// ----------------------------------------------------------------------------
module sha1sh_sched import sha1sh_pkg::*; (
  input  wire        clk,
  input  sched_ctl_t ctl,
  output word_t      w_cur
);

  word_t words [16];
  word_t mix;
  word_t w_new;

  // words[j] holds W[t+j] during round t
  assign mix   = words[13] ^ words[8] ^ words[2] ^ words[0];
  assign w_new = {mix[30:0], mix[31]};
  assign w_cur = words[0];

  always_ff @(posedge clk) begin
    if (ctl.shift) begin
      for (int j = 0; j < 15; j++) begin
        words[j] <= words[j+1];
      end
      words[15] <= w_new;
    end else if (ctl.wr_en) begin
      // big-endian: byte 0 of a word sits in bits 31:24
      words[ctl.wr_pos[5:2]][{~ctl.wr_pos[1:0], 3'b000} +: 8] <= ctl.wr_byte;
    end
  end

endmodule
`default_nettype wire

### rtl/sha1sh_round.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1sh_round
// SHA-1 round unit: working variables a..e, one round per step.
// ----------------------------------------------------------------------------
module sha1sh_round import sha1sh_pkg::*; (
  input  wire        clk,
  input  round_ctl_t ctl,
  input  chain_t     chain_in,
  input  word_t      w_in,
  output chain_t     work_out
);

  word_t a, b, c, d, e;
  word_t f, k, t;

  always_comb begin
    case (ctl.phase)
      PH_CHOOSE: begin
        f = (b & c) | (~b & d);
        k = 32'h5A827999;
      end
      PH_PARITY_LO: begin
        f = b ^ c ^ d;
        k = 32'h6ED9EBA1;
      end
      PH_MAJORITY: begin
        f = (b & c) | (b & d) | (c & d);
        k = 32'h8F1BBCDC;
      end
      default: begin
        f = b ^ c ^ d;
        k = 32'hCA62C1D6;
      end
    endcase
  end

  assign t        = {a[26:0], a[31:27]} + f + e + k + w_in;
  assign work_out = {e, d, c, b, a};

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      a <= chain_in[0];
      b <= chain_in[1];
      c <= chain_in[2];
      d <= chain_in[3];
      e <= chain_in[4];
    end else if (ctl.step) begin
      e <= d;
      d <= c;
      c <= {b[1:0], b[31:2]};
      b <= a;
      a <= t;
    end
  end

endmodule
`default_nettype wire

### rtl/sha1_stream_hasher_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sha1_stream_hasher_unit
// Byte-serial SHA-1 hasher with finish command and five-word digest output.
// ----------------------------------------------------------------------------
// A message enters one byte per input transfer (kind = 0); a transfer with
// kind = 1 closes the message, and the block then delivers the 160-bit digest
// as five output transfers, word 0 (H0) first, last_word set on word 4, and
// starts a fresh message. A data byte is written into the block buffer; the
// 64th byte of a block also runs the compression: the SHA-1 rounds on the
// single shared round unit, then the chaining add. A finish writes the 0x80
// mark, then the padding bytes (63 - fill) and the length, then runs the
// compression; when fewer than 9 bytes of the block were free, it pads a
// second block and runs another compression; then come the five digest
// words, one per output transfer. No new byte is taken while a compression
// runs. in_ready is high only while the block is waiting for input, and no
// input is taken while digest words are pending.
// ----------------------------------------------------------------------------
module sha1_stream_hasher_unit import sha1sh_pkg::*; (
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_ready,
  input  wire         kind,
  input  wire  [7:0]  data_byte,
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] digest_word,
  output logic [2:0]  word_number,
  output logic        last_word
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_ADD,
    S_OUT
  } state_t;

  localparam logic [6:0] LastRound = 7'(Rounds - 1);
  localparam logic [2:0] LastWord  = 3'(DigestWords - 1);

  state_t      state;
  chain_t      chain;
  logic [5:0]  fill;        // bytes held in the current block
  logic [60:0] msg_cnt;     // message length in bytes, wraps at 2^61
  logic [6:0]  rnd;
  logic [5:0]  pad_pos;
  logic        extra;       // padding needs a second block
  logic        final_blk;   // compression belongs to a finish
  logic [2:0]  out_idx;

  logic        in_xfer;
  logic        out_xfer;
  logic        start_cmp;
  logic [63:0] len_bits;
  logic [7:0]  len_byte;
  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;
  word_t       w_cur;
  chain_t      work;

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);
  assign in_xfer   = in_valid && in_ready;
  assign out_xfer  = out_valid && out_ready;

  // bit length, big-endian in bytes 56..63 of the final block
  assign len_bits = {msg_cnt, 3'b000};
  assign len_byte = len_bits[{~pad_pos[2:0], 3'b000} +: 8];

  // compression starts once byte 63 of a block is written
  assign start_cmp = (in_xfer && (fill == LAST_POS)) ||
                     ((state == S_PAD) && (pad_pos == LAST_POS));

  always_comb begin
    sched_ctl.shift = (state == S_ROUND);
    sched_ctl.wr_en = in_xfer || (state == S_PAD);
    if (state == S_PAD) begin
      sched_ctl.wr_pos  = pad_pos;
      sched_ctl.wr_byte = ((pad_pos >= LEN_POS) && !extra) ? len_byte : 8'h00;
    end else begin
      sched_ctl.wr_pos  = fill;
      sched_ctl.wr_byte = kind ? PAD_MARK : data_byte;
    end
  end

  always_comb begin
    round_ctl.load = start_cmp;
    round_ctl.step = (state == S_ROUND);
    if (rnd < 7'd20) begin
      round_ctl.phase = PH_CHOOSE;
    end else if (rnd < 7'd40) begin
      round_ctl.phase = PH_PARITY_LO;
    end else if (rnd < 7'd60) begin
      round_ctl.phase = PH_MAJORITY;
    end else begin
      round_ctl.phase = PH_PARITY_HI;
    end
  end

  sha1sh_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha1sh_round u_round (
    .clk      (clk),
    .ctl      (round_ctl),
    .chain_in (chain),
    .w_in     (w_cur),
    .work_out (work)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      chain     <= H_INIT;
      fill      <= '0;
      msg_cnt   <= '0;
      rnd       <= '0;
      pad_pos   <= '0;
      extra     <= 1'b0;
      final_blk <= 1'b0;
      out_idx   <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          rnd <= '0;
          if (in_xfer) begin
            if (!kind) begin
              fill    <= fill + 6'd1;
              msg_cnt <= msg_cnt + 61'd1;
              if (fill == LAST_POS) begin
                state <= S_ROUND;
              end
            end else begin
              // 0x80 goes in now; length fits only if at least 8 bytes remain
              final_blk <= 1'b1;
              extra     <= (fill >= LEN_POS);
              pad_pos   <= fill + 6'd1;
              state     <= (fill == LAST_POS) ? S_ROUND : S_PAD;
            end
          end
        end
        S_PAD: begin
          pad_pos <= pad_pos + 6'd1;
          rnd     <= '0;
          if (pad_pos == LAST_POS) begin
            state <= S_ROUND;
          end
        end
        S_ROUND: begin
          rnd <= rnd + 7'd1;
          if (rnd == LastRound) begin
            state <= S_ADD;
          end
        end
        S_ADD: begin
          for (int j = 0; j < DigestWords; j++) begin
            chain[j] <= chain[j] + work[j];
          end
          out_idx <= '0;
          if (!final_blk) begin
            state <= S_IDLE;
          end else if (extra) begin
            extra   <= 1'b0;
            pad_pos <= '0;
            state   <= S_PAD;
          end else begin
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_xfer) begin
            if (out_idx == LastWord) begin
              chain     <= H_INIT;
              fill      <= '0;
              msg_cnt   <= '0;
              final_blk <= 1'b0;
              state     <= S_IDLE;
            end else begin
              out_idx <= out_idx + 3'd1;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign digest_word = chain[out_idx];
  assign word_number = out_idx;
  assign last_word   = (out_idx == LastWord);

endmodule
`default_nettype wire
